// ===== rtl/psa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types and codes for the aging priority scheduler.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_ENQUEUE = 2'd1;
  localparam logic [1:0] OP_DEQUEUE = 2'd2;
  localparam logic [1:0] OP_DONE    = 2'd3;

  localparam logic [2:0] ST_NONE     = 3'd0;
  localparam logic [2:0] ST_ADDED    = 3'd1;
  localparam logic [2:0] ST_REMOVED  = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic CFG_AGING_STEP   = 1'b0;
  localparam logic CFG_PRIORITY_CAP = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  base_priority;
    logic [15:0] target_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] assigned_id;
    logic        running_valid;
    logic [15:0] running_id;
    logic [4:0]  waiting_count;
  } out_item_t;

  typedef struct packed {
    logic [15:0] id;
    logic [3:0]  base;
    logic [3:0]  level;
    logic [9:0]  age;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WRITE,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/psa_list_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psa_list_mem
// Wait list storage: one row holding all entries, registered read.
// ----------------------------------------------------------------------------
module psa_list_mem #(
  parameter int unsigned DEPTH = 16
) (
  input  wire                        clk,
  input  wire                        wr_en,
  input  wire psa_pkg::entry_t [DEPTH-1:0] wr_row,
  output psa_pkg::entry_t [DEPTH-1:0] rd_row
);
  import psa_pkg::*;

  entry_t [DEPTH-1:0] mem_r [1];
  entry_t [DEPTH-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[0] <= wr_row;
    end
    rd_r <= mem_r[0];
  end

  assign rd_row = rd_r;

endmodule
`default_nettype wire

// ===== rtl/psa_update.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// psa_update
// One tick of the scheduler over the wait list row: age, command, requeue,
// start of the head. Works lane by lane on the entries.
// ----------------------------------------------------------------------------
module psa_update #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CW    = 5
) (
  input  wire psa_pkg::in_item_t           item,
  input  wire psa_pkg::entry_t [DEPTH-1:0] row_in,
  input  wire [CW-1:0]                     count_in,
  input  wire                              run_valid_in,
  input  wire [15:0]                       run_id_in,
  input  wire [3:0]                        run_base_in,
  input  wire [15:0]                       next_id_in,
  input  wire [9:0]                        aging_step,
  input  wire [3:0]                        priority_cap,
  output psa_pkg::entry_t [DEPTH-1:0]      row_out,
  output logic [CW-1:0]                    count_out,
  output logic                             run_valid_out,
  output logic [15:0]                      run_id_out,
  output logic [3:0]                       run_base_out,
  output logic [15:0]                      next_id_out,
  output logic [2:0]                       status,
  output logic [15:0]                      assigned
);
  import psa_pkg::*;

  entry_t [DEPTH-1:0] aged;
  entry_t [DEPTH-1:0] cmd;
  entry_t [DEPTH-1:0] req;
  logic   [DEPTH-1:0] in_list;
  logic   [DEPTH-1:0] hit;
  logic   [DEPTH-1:0] first_hit;
  logic   [DEPTH-1:0] ins_hit;
  logic   [DEPTH-1:0] ins2_hit;
  logic   [DEPTH-1:0] rm_mask;
  logic   [DEPTH-1:0] ge_pos;
  logic   [DEPTH-1:0] ge_pos2;
  logic   [CW-1:0]    cnt1;
  logic   [CW-1:0]    cnt2;
  logic               run_v1;
  logic               full;
  logic               found;
  logic               found2;
  logic   [9:0]       age_inc;
  logic   [9:0]       step_eff;
  entry_t             new_e;
  entry_t             rq_e;

  always_comb begin
    step_eff = (aging_step == 10'd0) ? 10'd1 : aging_step;
    for (int i = 0; i < DEPTH; i++) begin
      in_list[i] = (CW'(i) < count_in);
      aged[i]    = row_in[i];
      age_inc    = row_in[i].age + 10'd1;
      if (in_list[i]) begin
        aged[i].age = age_inc;
        if (age_inc >= step_eff) begin
          aged[i].age = 10'd0;
          if (row_in[i].level < priority_cap) begin
            aged[i].level = row_in[i].level + 4'd1;
          end
        end
      end
    end
  end

  // command stage
  always_comb begin
    cmd       = aged;
    cnt1      = count_in;
    run_v1    = run_valid_in;
    status    = ST_NONE;
    assigned  = 16'd0;
    found     = 1'b0;
    next_id_out = next_id_in;
    full      = ({1'b0, count_in} + {{CW{1'b0}}, run_valid_in}) >= (CW+1)'(DEPTH);
    new_e.id    = next_id_in;
    new_e.base  = item.base_priority;
    new_e.level = item.base_priority;
    new_e.age   = 10'd0;
    for (int i = 0; i < DEPTH; i++) begin
      ge_pos[i] = in_list[i] && !(aged[i].level < item.base_priority);
      hit[i]    = in_list[i] && (aged[i].id == item.target_id);
    end
    first_hit = hit & ~(hit - DEPTH'(1));
    rm_mask   = {DEPTH{1'b0}};
    ins_hit   = {DEPTH{1'b0}};
    case (item.operation)
      OP_ENQUEUE: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          status      = ST_ADDED;
          assigned    = next_id_in;
          next_id_out = next_id_in + 16'd1;
          cnt1        = count_in + CW'(1);
          // insert before the first entry of lower level
          for (int i = 0; i < DEPTH; i++) begin
            ins_hit[i] = !ge_pos[i] && !found;
            if (ins_hit[i]) begin
              cmd[i] = new_e;
            end else if (found) begin
              cmd[i] = aged[(i == 0) ? 0 : i - 1];
            end
            found = found | ins_hit[i];
          end
        end
      end
      OP_DEQUEUE: begin
        status = ST_NOTFOUND;
        if (run_valid_in && run_id_in == item.target_id) begin
          run_v1 = 1'b0;
          status = ST_REMOVED;
        end else if (hit != '0) begin
          status  = ST_REMOVED;
          cnt1    = count_in - CW'(1);
          rm_mask = ~((first_hit - DEPTH'(1)) | first_hit) | first_hit;
          rm_mask = ~(first_hit - DEPTH'(1));
          for (int i = 0; i < DEPTH; i++) begin
            if (rm_mask[i] && i + 1 < DEPTH) begin
              cmd[i] = aged[(i + 1) % DEPTH];
            end
          end
        end
      end
      default: ;
    endcase
  end

  // requeue running job, then pop head
  always_comb begin
    req    = cmd;
    cnt2   = cnt1;
    found2 = 1'b0;
    rq_e.id    = run_id_in;
    rq_e.base  = run_base_in;
    rq_e.level = run_base_in;
    rq_e.age   = 10'd0;
    for (int i = 0; i < DEPTH; i++) begin
      ge_pos2[i] = (CW'(i) < cnt1) && !(cmd[i].level < run_base_in);
    end
    for (int i = 0; i < DEPTH; i++) begin
      ins2_hit[i] = !ge_pos2[i] && !found2;
      if (run_v1) begin
        if (ins2_hit[i]) begin
          req[i] = rq_e;
        end else if (found2) begin
          req[i] = cmd[(i == 0) ? 0 : i - 1];
        end
      end
      found2 = found2 | ins2_hit[i];
    end
    if (run_v1) begin
      cnt2 = cnt1 + CW'(1);
    end
    run_valid_out = 1'b0;
    run_id_out    = run_id_in;
    run_base_out  = run_base_in;
    row_out       = req;
    count_out     = cnt2;
    if (cnt2 != '0) begin
      run_valid_out = 1'b1;
      run_id_out    = req[0].id;
      run_base_out  = req[0].base;
      count_out     = cnt2 - CW'(1);
      for (int i = 0; i + 1 < DEPTH; i++) begin
        row_out[i] = req[i+1];
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/priority_scheduler_with_aging_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// priority_scheduler_with_aging_top
// Time-slice scheduler with aging over a bounded wait list.
// Transactions are handled one at a time, in the steps accept, row read, update
//   and write back, result; a new one is taken only after the result is taken,
//   as set by the read-modify-write of the row.
// Reset: control, run slot, id counter and list count clear; registers take
//   aging_step 10 and priority_cap 3; list entries undefined until written.
// ----------------------------------------------------------------------------
module priority_scheduler_with_aging_top #(
  parameter int unsigned LIST_DEPTH = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire psa_pkg::in_item_t in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output psa_pkg::out_item_t out_data,
  input  wire               cfg_we,
  input  wire [0:0]         cfg_index,
  input  wire [9:0]         cfg_wdata
);
  import psa_pkg::*;

  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  state_t state_r, state_nxt;
  in_item_t item_r;
  out_item_t out_r, out_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic run_valid_r, run_valid_nxt;
  logic [15:0] run_id_r, run_id_nxt;
  logic [3:0] run_base_r, run_base_nxt;
  logic [15:0] next_id_r, next_id_nxt;
  logic [9:0] aging_step_r;
  logic [3:0] priority_cap_r;
  logic mem_we;

  entry_t [LIST_DEPTH-1:0] rd_row, wr_row;
  logic [CW-1:0] u_count;
  logic u_rv;
  logic [15:0] u_rid, u_nid, u_assigned;
  logic [3:0] u_rbase;
  logic [2:0] u_status;

  psa_list_mem #(.DEPTH(LIST_DEPTH)) u_mem (
    .clk(clk), .wr_en(mem_we), .wr_row(wr_row), .rd_row(rd_row)
  );

  psa_update #(.DEPTH(LIST_DEPTH), .CW(CW)) u_upd (
    .item(item_r), .row_in(rd_row), .count_in(count_r),
    .run_valid_in(run_valid_r), .run_id_in(run_id_r), .run_base_in(run_base_r),
    .next_id_in(next_id_r), .aging_step(aging_step_r),
    .priority_cap(priority_cap_r), .row_out(wr_row), .count_out(u_count),
    .run_valid_out(u_rv), .run_id_out(u_rid), .run_base_out(u_rbase),
    .next_id_out(u_nid), .status(u_status), .assigned(u_assigned)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aging_step_r   <= 10'd10;
      priority_cap_r <= 4'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AGING_STEP:   aging_step_r   <= cfg_wdata;
        CFG_PRIORITY_CAP: priority_cap_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      run_valid_r <= 1'b0;
      run_id_r    <= 16'd0;
      run_base_r  <= 4'd0;
      next_id_r   <= 16'd0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      run_valid_r <= run_valid_nxt;
      run_id_r    <= run_id_nxt;
      run_base_r  <= run_base_nxt;
      next_id_r   <= next_id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      item_r <= in_data;
    end
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    run_valid_nxt = run_valid_r;
    run_id_nxt    = run_id_r;
    run_base_nxt  = run_base_r;
    next_id_nxt   = next_id_r;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_WRITE;
      S_WRITE: begin
        state_nxt = S_OUT;
        if (item_r.operation == OP_DONE) begin
          run_valid_nxt = 1'b0;
          out_nxt.status      = ST_NONE;
          out_nxt.assigned_id = 16'd0;
        end else begin
          mem_we        = 1'b1;
          count_nxt     = u_count;
          run_valid_nxt = u_rv;
          run_id_nxt    = u_rid;
          run_base_nxt  = u_rbase;
          next_id_nxt   = u_nid;
          out_nxt.status      = u_status;
          out_nxt.assigned_id = u_assigned;
        end
        out_nxt.running_valid = run_valid_nxt;
        out_nxt.running_id    = run_valid_nxt ? run_id_nxt : 16'd0;
        out_nxt.waiting_count = 5'(count_nxt);
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_data = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(LIST_DEPTH)) else $error("list count over depth");
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.running_valid) |-> out_data.running_id == 16'd0)
    else $error("running id without job");
  a_id_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_ADDED) |-> next_id_r == out_data.assigned_id + 16'd1)
    else $error("id counter mismatch");

endmodule
`default_nettype wire

// ===== tb/priority_scheduler_with_aging_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_scheduler_with_aging_top_test
// Self-checking bench for the aging priority scheduler: a queued driver and a
// stalling monitor check every result against an in-bench scheduler model.
// ----------------------------------------------------------------------------
module priority_scheduler_with_aging_top_test;
  import psa_pkg::*;

  localparam int DEPTH = 16;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [9:0] cfg_wdata;

  priority_scheduler_with_aging_top #(.LIST_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // scheduler model state
  logic [15:0] wl_id [DEPTH];
  logic [3:0] wl_base [DEPTH];
  logic [3:0] wl_level [DEPTH];
  logic [9:0] wl_age [DEPTH];
  int wl_count;
  logic run_busy;
  logic [15:0] run_job;
  logic [3:0] run_base;
  logic [15:0] id_counter;
  logic [9:0] step_cfg;
  logic [3:0] cap_cfg;

  in_item_t pending_q[$];
  out_item_t expected_q[$];
  int error_count;
  int accepted_in;
  int accepted_out;
  int idle_cycles;
  int send_gap;
  int recv_gap;
  int cfg_phases;
  bit hold_send;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void wl_insert(logic [15:0] id, logic [3:0] base);
    int pos;
    pos = 0;
    if (wl_count >= DEPTH) return;
    while (pos < wl_count && !(wl_level[pos] < base)) pos++;
    for (int k = wl_count; k > pos; k--) begin
      wl_id[k] = wl_id[k-1];
      wl_base[k] = wl_base[k-1];
      wl_level[k] = wl_level[k-1];
      wl_age[k] = wl_age[k-1];
    end
    wl_id[pos] = id;
    wl_base[pos] = base;
    wl_level[pos] = base;
    wl_age[pos] = '0;
    wl_count++;
  endfunction

  function automatic void wl_remove(int pos);
    for (int k = pos; k + 1 < wl_count; k++) begin
      wl_id[k] = wl_id[k+1];
      wl_base[k] = wl_base[k+1];
      wl_level[k] = wl_level[k+1];
      wl_age[k] = wl_age[k+1];
    end
    wl_count--;
  endfunction

  function automatic out_item_t schedule_slice(in_item_t it);
    out_item_t r;
    r = '0;
    if (it.operation == OP_DONE) begin
      run_busy = 1'b0;
    end else begin
      for (int k = 0; k < wl_count; k++) begin
        wl_age[k] = wl_age[k] + 10'd1;
        if (wl_age[k] >= step_cfg) begin
          wl_age[k] = '0;
          if (wl_level[k] < cap_cfg) wl_level[k]++;
        end
      end
      if (it.operation == OP_ENQUEUE) begin
        if (wl_count + (run_busy ? 1 : 0) >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          r.assigned_id = id_counter;
          wl_insert(id_counter, it.base_priority);
          id_counter = id_counter + 16'd1;
          r.status = ST_ADDED;
        end
      end else if (it.operation == OP_DEQUEUE) begin
        r.status = ST_NOTFOUND;
        if (run_busy && run_job == it.target_id) begin
          run_busy = 1'b0;
          r.status = ST_REMOVED;
        end else begin
          for (int k = 0; k < wl_count; k++) begin
            if (wl_id[k] == it.target_id) begin
              wl_remove(k);
              r.status = ST_REMOVED;
              break;
            end
          end
        end
      end
      if (run_busy) begin
        wl_insert(run_job, run_base);
        run_busy = 1'b0;
      end
      if (wl_count > 0) begin
        run_job = wl_id[0];
        run_base = wl_base[0];
        run_busy = 1'b1;
        wl_remove(0);
      end
    end
    r.running_valid = run_busy;
    r.running_id = run_busy ? run_job : 16'd0;
    r.waiting_count = wl_count[4:0];
    return r;
  endfunction

  // pick a dequeue target that is usually a live job
  function automatic logic [15:0] pick_target();
    int n;
    n = $urandom_range(0, 9);
    if (n < 3 && run_busy) return run_job;
    if (n < 7 && wl_count > 0) return wl_id[$urandom_range(0, wl_count - 1)];
    if (n == 7) return id_counter;
    return 16'($urandom());
  endfunction

  function automatic in_item_t make_item(logic [1:0] op, logic [3:0] base,
                                         logic [15:0] target);
    in_item_t it;
    it.operation = op;
    it.base_priority = base;
    it.target_id = target;
    return it;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      send_gap <= 0;
    end else if (in_valid && !in_stall) begin
      expected_q.push_back(schedule_slice(in_data));
      accepted_in <= accepted_in + 1;
      if (pending_q.size() > 0 && !hold_send && $urandom_range(0, 3) == 0) begin
        in_data <= pending_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
        send_gap <= (hold_send || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
      end
    end else if (!in_valid) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_q.size() > 0 && !hold_send) begin
        in_data <= pending_q.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        accepted_out <= accepted_out + 1;
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction %p", out_data);
          error_count++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_data.status !== exp_r.status) begin
            $error("status expected %0d got %0d", exp_r.status, out_data.status);
            error_count++;
          end
          if (out_data.assigned_id !== exp_r.assigned_id) begin
            $error("assigned_id expected %0d got %0d", exp_r.assigned_id,
                   out_data.assigned_id);
            error_count++;
          end
          if (out_data.running_valid !== exp_r.running_valid) begin
            $error("running_valid expected %0d got %0d", exp_r.running_valid,
                   out_data.running_valid);
            error_count++;
          end
          if (out_data.running_id !== exp_r.running_id) begin
            $error("running_id expected %0d got %0d", exp_r.running_id,
                   out_data.running_id);
            error_count++;
          end
          if (out_data.waiting_count !== exp_r.waiting_count) begin
            $error("waiting_count expected %0d got %0d", exp_r.waiting_count,
                   out_data.waiting_count);
            error_count++;
          end
        end
        recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
        out_stall <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [9:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_AGING_STEP) step_cfg = val;
    else cap_cfg = val[3:0];
    cfg_phases++;
  endtask

  // mostly enqueue/tick/dequeue mixes to fill, age, and drain the list
  task automatic queue_random(int count, int enq_weight);
    int n;
    logic [1:0] op;
    for (int i = 0; i < count; i++) begin
      n = $urandom_range(0, 99);
      if (n < enq_weight) op = OP_ENQUEUE;
      else if (n < enq_weight + 25) op = OP_TICK;
      else if (n < enq_weight + 45) op = OP_DEQUEUE;
      else op = OP_DONE;
      pending_q.push_back(make_item(op, 4'($urandom()), 16'($urandom())));
    end
  endtask

  // most dequeues get the fixed target id FFFF, then the phase is drained
  task automatic run_phase(int count, int enq_weight);
    in_item_t it;
    queue_random(count, enq_weight);
    foreach (pending_q[i]) begin
      if (pending_q[i].operation == OP_DEQUEUE && $urandom_range(0, 4) != 0)
        pending_q[i].target_id = 16'hFFFF;
    end
    drain();
  endtask

  initial begin
    logic [9:0] steps [5];
    logic [3:0] caps [5];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    error_count = 0;
    accepted_in = 0;
    accepted_out = 0;
    cfg_phases = 0;
    hold_send = 1'b0;
    wl_count = 0;
    run_busy = 1'b0;
    run_job = '0;
    run_base = '0;
    id_counter = '0;
    step_cfg = 10'd10;
    cap_cfg = 4'd3;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty ops, fill to full, extremes, dequeue of running and waiting
    pending_q.push_back(make_item(OP_TICK, 4'd0, 16'd0));
    pending_q.push_back(make_item(OP_DEQUEUE, 4'd0, 16'hFFFF));
    pending_q.push_back(make_item(OP_DONE, 4'hF, 16'hFFFF));
    for (int i = 0; i < 17; i++)
      pending_q.push_back(make_item(OP_ENQUEUE, 4'(i), 16'hAAAA));
    pending_q.push_back(make_item(OP_DEQUEUE, 4'd0, 16'd0));
    pending_q.push_back(make_item(OP_DEQUEUE, 4'd0, 16'd5));
    pending_q.push_back(make_item(OP_DONE, 4'd0, 16'd0));
    pending_q.push_back(make_item(OP_TICK, 4'hF, 16'h5555));
    drain();

    steps = '{10'd1, 10'd0, 10'd1023, 10'd3, 10'd2};
    caps = '{4'd15, 4'd0, 4'd15, 4'd7, 4'd3};
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_AGING_STEP, steps[p]);
      write_reg(CFG_PRIORITY_CAP, {6'($urandom()), caps[p]});
      // sender held back once, while five random items are queued
      if (p == 2) begin
        hold_send = 1'b1;
        queue_random(5, 50);
        repeat (20) @(posedge clk);
        hold_send = 1'b0;
      end
      for (int b = 0; b < 6; b++) begin
        queue_random(1, 0);
        void'(pending_q.pop_back());
        for (int i = 0; i < 30; i++) begin
          if ($urandom_range(0, 99) < 30)
            pending_q.push_back(make_item(OP_DEQUEUE, 4'($urandom()), 16'($urandom())));
          else
            pending_q.push_back(make_item(OP_ENQUEUE, 4'($urandom()),
                                          16'($urandom())));
        end
        while (pending_q.size() > 0) begin
          @(posedge clk);
          if (!in_valid && pending_q.size() > 0 &&
              pending_q[0].operation == OP_DEQUEUE)
            pending_q[0].target_id = pick_target();
        end
      end
      queue_random(6, 20);
      drain();
    end

    $display("Covered %0d input and %0d result transactions over %0d register writes.",
             accepted_in, accepted_out, cfg_phases);
    $display("Mixes included full list, id lookups, job completion and cap/step extremes.");
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
